// ----- design/assert_macros.svh -----
// assertion helpers used by the top unit's checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property, checked outside reset
`define CRSG_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// implication, checked outside reset
`define CRSG_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ----- design/crsg_pkg.sv -----
`default_nettype none

package crsg_pkg;

    localparam int CFG_IDX_W = 3;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_CENTER_X      = 3'd0;
    localparam t_cfg_idx CFG_CENTER_Y      = 3'd1;
    localparam t_cfg_idx CFG_OUTER_RADIUS  = 3'd2;
    localparam t_cfg_idx CFG_BORDER_WIDTH  = 3'd3;
    localparam t_cfg_idx CFG_FILL_ENABLE   = 3'd4;
    localparam t_cfg_idx CFG_BORDER_ENABLE = 3'd5;

    // row classification handed from front to back
    typedef struct packed {
        logic fill_go;
        logic bord_go;
        logic inner_hit;
    } t_class;

endpackage

`default_nettype wire

// ----- design/crsg_ifs.sv -----
`default_nettype none

interface crsg_row_if #(
    parameter int P_CI = 12
);
    logic            valid;
    logic            ready;
    logic [P_CI-1:0] row;

    modport source (output valid, output row, input ready);
    modport sink   (input valid, input row, output ready);
endinterface

interface crsg_span_if #(
    parameter int P_CI = 12
);
    localparam int CO = P_CI + 2;

    logic                  valid;
    logic                  ready;
    logic [P_CI-1:0]       row_out;
    logic                  fill_valid;
    logic signed [CO-1:0]  fill_first;
    logic signed [CO-1:0]  fill_last;
    logic                  left_valid;
    logic signed [CO-1:0]  left_first;
    logic signed [CO-1:0]  left_last;
    logic                  right_valid;
    logic signed [CO-1:0]  right_first;
    logic signed [CO-1:0]  right_last;

    modport source (
        output valid, output row_out,
        output fill_valid, output fill_first, output fill_last,
        output left_valid, output left_first, output left_last,
        output right_valid, output right_first, output right_last,
        input ready
    );
    modport sink (
        input valid, input row_out,
        input fill_valid, input fill_first, input fill_last,
        input left_valid, input left_first, input left_last,
        input right_valid, input right_first, input right_last,
        output ready
    );
endinterface

interface crsg_cfg_if #(
    parameter int P_CI = 12,
    parameter int P_CF = 4
);
    localparam int DW = P_CI + P_CF;

    logic               valid;
    logic               ready;
    crsg_pkg::t_cfg_idx index;
    logic [DW-1:0]      data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- design/circle_ring_span_generator_unit.sv -----
// channel   dir  handshake          payload
// i_row     in   valid / ready      row
// o_span    out  valid / ready      row_out, fill/left/right valid, first, last
// i_cfg     in   valid / ready (=1) index, data
//
// one row per cycle sustained while o_span.ready holds; a row passes 3 front stages,
// the queue write, one stage per root bit and the output register
// the two pipelined square roots set the depth, 15 stages at default widths
// reset (synchronous, active low) clears all config registers, queue and valids
// a stalled output freezes the back end; the 4-entry queue lets the front keep
// taking rows until it fills, then i_row.ready drops
`default_nettype none
`include "assert_macros.svh"

module circle_ring_span_generator_unit #(
    parameter int COORD_INT_BITS  = 12,
    parameter int COORD_FRAC_BITS = 4
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    crsg_row_if.sink      i_row,
    crsg_span_if.source   o_span,
    crsg_cfg_if.sink      i_cfg
);

    localparam int CI      = COORD_INT_BITS;
    localparam int CF      = COORD_FRAC_BITS;
    localparam int CW      = CI + CF;
    localparam int L       = CW - 1;
    localparam int CLS_W   = $bits(crsg_pkg::t_class);
    localparam int QW      = CI + 4 * L + CLS_W;
    localparam int Q_DEPTH = 4;

    logic [CW-1:0]      r_center_x, r_center_y;
    logic [L-1:0]       r_outer_radius, r_border_width;
    logic               r_fill_enable, r_border_enable;

    logic               w_f_valid, w_q_full, w_q_empty, w_b_ready;
    logic [CI-1:0]      w_f_row;
    logic [2*L-1:0]     w_f_in_rad, w_f_out_rad;
    crsg_pkg::t_class   w_f_cls;
    logic [QW-1:0]      w_q_in, w_q_out;
    logic [CI-1:0]      w_q_row;
    logic [2*L-1:0]     w_q_in_rad, w_q_out_rad;
    crsg_pkg::t_class   w_q_cls;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x      <= '0;
            r_center_y      <= '0;
            r_outer_radius  <= '0;
            r_border_width  <= '0;
            r_fill_enable   <= 1'b0;
            r_border_enable <= 1'b0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                crsg_pkg::CFG_CENTER_X:      r_center_x      <= i_cfg.data;
                crsg_pkg::CFG_CENTER_Y:      r_center_y      <= i_cfg.data;
                crsg_pkg::CFG_OUTER_RADIUS:  r_outer_radius  <= i_cfg.data[L-1:0];
                crsg_pkg::CFG_BORDER_WIDTH:  r_border_width  <= i_cfg.data[L-1:0];
                crsg_pkg::CFG_FILL_ENABLE:   r_fill_enable   <= i_cfg.data[0];
                crsg_pkg::CFG_BORDER_ENABLE: r_border_enable <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

    crsg_front #(.P_CI(CI), .P_CF(CF)) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_row.valid),
        .o_ready         (i_row.ready),
        .i_row           (i_row.row),
        .i_center_y      (r_center_y),
        .i_outer_radius  (r_outer_radius),
        .i_border_width  (r_border_width),
        .i_fill_enable   (r_fill_enable),
        .i_border_enable (r_border_enable),
        .o_valid         (w_f_valid),
        .i_ready         (!w_q_full),
        .o_row           (w_f_row),
        .o_in_rad        (w_f_in_rad),
        .o_out_rad       (w_f_out_rad),
        .o_cls           (w_f_cls)
    );

    assign w_q_in = {w_f_row, w_f_in_rad, w_f_out_rad, w_f_cls};

    crsg_queue #(.P_W(QW), .P_DEPTH(Q_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_f_valid && !w_q_full),
        .i_data  (w_q_in),
        .o_full  (w_q_full),
        .i_pop   (w_b_ready && !w_q_empty),
        .o_data  (w_q_out),
        .o_empty (w_q_empty)
    );

    assign w_q_row     = w_q_out[QW-1 -: CI];
    assign w_q_in_rad  = w_q_out[4*L+CLS_W-1 -: 2*L];
    assign w_q_out_rad = w_q_out[2*L+CLS_W-1 -: 2*L];
    assign w_q_cls     = w_q_out[CLS_W-1:0];

    crsg_back #(.P_CI(CI), .P_CF(CF)) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (!w_q_empty),
        .o_ready       (w_b_ready),
        .i_row         (w_q_row),
        .i_in_rad      (w_q_in_rad),
        .i_out_rad     (w_q_out_rad),
        .i_cls         (w_q_cls),
        .i_center_x    (r_center_x),
        .o_valid       (o_span.valid),
        .i_ready       (o_span.ready),
        .o_row_out     (o_span.row_out),
        .o_fill_valid  (o_span.fill_valid),
        .o_fill_first  (o_span.fill_first),
        .o_fill_last   (o_span.fill_last),
        .o_left_valid  (o_span.left_valid),
        .o_left_first  (o_span.left_first),
        .o_left_last   (o_span.left_last),
        .o_right_valid (o_span.right_valid),
        .o_right_first (o_span.right_first),
        .o_right_last  (o_span.right_last)
    );

    `CRSG_ASSERT(a_fill_zero, !(o_span.valid && !o_span.fill_valid) || (o_span.fill_first == '0 && o_span.fill_last == '0), "empty fill span has nonzero ends")
    `CRSG_ASSERT_IMP(a_left_order, o_span.valid && o_span.left_valid, o_span.left_last >= o_span.left_first, "left span ends reversed")
    `CRSG_ASSERT_IMP(a_right_border, o_span.valid && o_span.right_valid, r_border_enable && r_border_width != '0, "right span without border")
    `CRSG_ASSERT_IMP(a_fill_inner, o_span.valid && o_span.fill_valid, r_fill_enable && (r_outer_radius > r_border_width), "fill span without inner circle")

endmodule

`default_nettype wire

// ----- design/crsg_front.sv -----
`default_nettype none

module crsg_front #(
    parameter int P_CI = 12,
    parameter int P_CF = 4
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire logic [P_CI-1:0]              i_row,
    input  wire logic [P_CI+P_CF-1:0]         i_center_y,
    input  wire logic [P_CI+P_CF-2:0]         i_outer_radius,
    input  wire logic [P_CI+P_CF-2:0]         i_border_width,
    input  wire logic                         i_fill_enable,
    input  wire logic                         i_border_enable,
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output logic [P_CI-1:0]                   o_row,
    output logic [2*(P_CI+P_CF-1)-1:0]        o_in_rad,
    output logic [2*(P_CI+P_CF-1)-1:0]        o_out_rad,
    output crsg_pkg::t_class                  o_cls
);

    localparam int CW   = P_CI + P_CF;
    localparam int L    = CW - 1;
    localparam int DW   = CW + 2;
    localparam int HALF = 1 << (P_CF - 1);

    logic [2:0]          r_v;
    logic                w_adv;
    logic [P_CI-1:0]     r_row0, r_row1, r_row2;
    logic [CW-1:0]       r_abs1;
    logic [L-1:0]        r_fr1;
    logic [2*CW-1:0]     r_dy_sq;
    logic [2*L-1:0]      r_fr_sq;
    logic [2*L-1:0]      r_r_sq;

    logic signed [DW-1:0] w_dy;
    logic [DW-1:0]        w_neg;
    logic [CW-1:0]        w_abs;
    logic [L-1:0]         w_fr;
    logic                 w_in_ge, w_out_ge;
    logic [2*CW-1:0]      w_in_diff, w_out_diff;

    assign w_adv   = !r_v[2] || i_ready;
    assign o_ready = w_adv;

    // sample point sits half a pixel below the row index
    assign w_dy  = $signed({2'b00, r_row0, {P_CF{1'b0}}}) + $signed(DW'(HALF))
                 - $signed({2'b00, i_center_y});
    assign w_neg = -w_dy;
    assign w_abs = w_dy[DW-1] ? w_neg[CW-1:0] : w_dy[CW-1:0];
    assign w_fr  = (i_outer_radius > i_border_width) ? (i_outer_radius - i_border_width) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (w_adv) begin
            r_v <= {r_v[1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_row0  <= i_row;
            r_row1  <= r_row0;
            r_abs1  <= w_abs;
            r_fr1   <= w_fr;
            r_row2  <= r_row1;
            r_dy_sq <= r_abs1 * r_abs1;
            r_fr_sq <= r_fr1 * r_fr1;
            r_r_sq  <= i_outer_radius * i_outer_radius;
        end
    end

    assign w_in_ge    = {2'b00, r_fr_sq} >= r_dy_sq;
    assign w_out_ge   = {2'b00, r_r_sq} >= r_dy_sq;
    assign w_in_diff  = {2'b00, r_fr_sq} - r_dy_sq;
    assign w_out_diff = {2'b00, r_r_sq} - r_dy_sq;

    assign o_valid   = r_v[2];
    assign o_row     = r_row2;
    assign o_in_rad  = w_in_ge ? w_in_diff[2*L-1:0] : '0;
    assign o_out_rad = w_out_ge ? w_out_diff[2*L-1:0] : '0;

    always_comb begin
        o_cls           = '0;
        o_cls.fill_go   = i_fill_enable && (i_outer_radius > i_border_width) && w_in_ge;
        o_cls.bord_go   = i_border_enable && (i_border_width != '0) && w_out_ge;
        o_cls.inner_hit = w_in_ge;
    end

endmodule

`default_nettype wire

// ----- design/crsg_queue.sv -----
`default_nettype none

module crsg_queue #(
    parameter int P_W     = 64,
    parameter int P_DEPTH = 4
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire logic [P_W-1:0] i_data,
    output logic                o_full,
    input  wire logic           i_pop,
    output logic [P_W-1:0]      o_data,
    output logic                o_empty
);

    localparam int AW = $clog2(P_DEPTH);
    localparam int NW = $clog2(P_DEPTH + 1);

    logic [P_W-1:0] r_mem [P_DEPTH];
    logic [AW-1:0]  r_wr, r_rd;
    logic [NW-1:0]  r_cnt;

    assign o_full  = r_cnt == NW'(P_DEPTH);
    assign o_empty = r_cnt == '0;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == AW'(P_DEPTH - 1)) ? '0 : r_wr + AW'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == AW'(P_DEPTH - 1)) ? '0 : r_rd + AW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + NW'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - NW'(1);
            end
        end
    end

endmodule

`default_nettype wire

// ----- design/crsg_root.sv -----
`default_nettype none

module crsg_root #(
    parameter int P_W = 30
) (
    input  wire logic             i_clk,
    input  wire logic             i_en,
    input  wire logic [P_W-1:0]   i_rad,
    output logic [P_W/2-1:0]      o_root
);

    localparam int NB = P_W / 2;
    localparam int RW = NB + 2;
    localparam int XW = NB + 4;

    // one root bit per stage, two radicand bits consumed each stage
    logic [P_W-1:0] r_x   [NB];
    logic [RW-1:0]  r_rem [NB];
    logic [NB-1:0]  r_q   [NB];

    logic [P_W-1:0] w_x_in   [NB];
    logic [RW-1:0]  w_rem_in [NB];
    logic [NB-1:0]  w_q_in   [NB];
    logic [XW-1:0]  w_cat    [NB];
    logic [XW-1:0]  w_trial  [NB];
    logic [XW-1:0]  w_diff   [NB];
    logic [NB-1:0]  w_ge;

    always_comb begin
        for (int s = 0; s < NB; s++) begin
            if (s == 0) begin
                w_x_in[s]   = i_rad;
                w_rem_in[s] = '0;
                w_q_in[s]   = '0;
            end else begin
                w_x_in[s]   = r_x[s-1];
                w_rem_in[s] = r_rem[s-1];
                w_q_in[s]   = r_q[s-1];
            end
            w_cat[s]   = {w_rem_in[s], w_x_in[s][P_W-1 -: 2]};
            w_trial[s] = {2'b00, w_q_in[s], 2'b01};
            w_ge[s]    = w_cat[s] >= w_trial[s];
            w_diff[s]  = w_cat[s] - w_trial[s];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int s = 0; s < NB; s++) begin
                r_x[s]   <= {w_x_in[s][P_W-3:0], 2'b00};
                r_rem[s] <= w_ge[s] ? w_diff[s][RW-1:0] : w_cat[s][RW-1:0];
                r_q[s]   <= {w_q_in[s][NB-2:0], w_ge[s]};
            end
        end
    end

    assign o_root = r_q[NB-1];

endmodule

`default_nettype wire

// ----- design/crsg_back.sv -----
`default_nettype none

module crsg_back #(
    parameter int P_CI = 12,
    parameter int P_CF = 4
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire logic [P_CI-1:0]              i_row,
    input  wire logic [2*(P_CI+P_CF-1)-1:0]   i_in_rad,
    input  wire logic [2*(P_CI+P_CF-1)-1:0]   i_out_rad,
    input  wire crsg_pkg::t_class             i_cls,
    input  wire logic [P_CI+P_CF-1:0]         i_center_x,
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output logic [P_CI-1:0]                   o_row_out,
    output logic                              o_fill_valid,
    output logic signed [P_CI+1:0]            o_fill_first,
    output logic signed [P_CI+1:0]            o_fill_last,
    output logic                              o_left_valid,
    output logic signed [P_CI+1:0]            o_left_first,
    output logic signed [P_CI+1:0]            o_left_last,
    output logic                              o_right_valid,
    output logic signed [P_CI+1:0]            o_right_first,
    output logic signed [P_CI+1:0]            o_right_last
);

    localparam int CW     = P_CI + P_CF;
    localparam int L      = CW - 1;
    localparam int SW     = CW + 2;
    localparam int CO     = P_CI + 2;
    localparam int ONE_M1 = (1 << P_CF) - 1;

    logic                 w_adv;
    logic [L-1:0]         w_din, w_dout;
    logic [L-1:0]         r_sv;
    logic [P_CI-1:0]      r_srow [L];
    crsg_pkg::t_class     r_scls [L];
    crsg_pkg::t_class     w_cls;

    logic signed [SW-1:0] w_cx, w_do, w_di, w_a, w_b, w_c, w_d;
    logic signed [CO-1:0] w_ff, w_fl, w_lf, w_ll, w_rf, w_rl;
    logic                 w_fv, w_lv, w_rv;

    logic                 r_ov;
    logic [P_CI-1:0]      r_row;
    logic                 r_fv, r_lv, r_rv;
    logic signed [CO-1:0] r_ff, r_fl, r_lf, r_ll, r_rf, r_rl;

    function automatic logic signed [CO-1:0] f_floor(input logic signed [SW-1:0] v);
        return v[SW-1:P_CF];
    endfunction

    function automatic logic signed [CO-1:0] f_ceil(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] t;
        t = v + $signed(SW'(ONE_M1));
        return t[SW-1:P_CF];
    endfunction

    // whole back end moves together; the output register is its last stage
    assign w_adv   = !r_ov || i_ready;
    assign o_ready = w_adv;

    crsg_root #(.P_W(2 * L)) u_root_in (
        .i_clk  (i_clk),
        .i_en   (w_adv),
        .i_rad  (i_in_rad),
        .o_root (w_din)
    );

    crsg_root #(.P_W(2 * L)) u_root_out (
        .i_clk  (i_clk),
        .i_en   (w_adv),
        .i_rad  (i_out_rad),
        .o_root (w_dout)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv <= '0;
            r_ov <= 1'b0;
        end else if (w_adv) begin
            r_sv <= {r_sv[L-2:0], i_valid};
            r_ov <= r_sv[L-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_srow[0] <= i_row;
            r_scls[0] <= i_cls;
            for (int k = 1; k < L; k++) begin
                r_srow[k] <= r_srow[k-1];
                r_scls[k] <= r_scls[k-1];
            end
        end
    end

    assign w_cls = r_scls[L-1];
    assign w_cx  = $signed({2'b00, i_center_x});
    assign w_do  = $signed({3'b000, w_dout});
    assign w_di  = $signed({3'b000, w_din});
    assign w_a   = w_cx - w_do;
    assign w_b   = w_cx + w_do;
    assign w_c   = w_cx - w_di;
    assign w_d   = w_cx + w_di;

    always_comb begin
        w_ff = f_floor(w_c);
        w_fl = f_ceil(w_d);
        w_lf = f_floor(w_a);
        // a row that misses the inner circle gives one whole span
        w_ll = w_cls.inner_hit ? (f_ceil(w_c) - CO'(1)) : f_ceil(w_b);
        w_rf = f_ceil(w_d);
        w_rl = f_floor(w_b);
        w_fv = w_cls.fill_go && (w_fl >= w_ff);
        w_lv = w_cls.bord_go && (w_ll >= w_lf);
        w_rv = w_cls.bord_go && w_cls.inner_hit && (w_rl >= w_rf);
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_row <= r_srow[L-1];
            r_fv  <= w_fv;
            r_ff  <= w_fv ? w_ff : '0;
            r_fl  <= w_fv ? w_fl : '0;
            r_lv  <= w_lv;
            r_lf  <= w_lv ? w_lf : '0;
            r_ll  <= w_lv ? w_ll : '0;
            r_rv  <= w_rv;
            r_rf  <= w_rv ? w_rf : '0;
            r_rl  <= w_rv ? w_rl : '0;
        end
    end

    assign o_valid       = r_ov;
    assign o_row_out     = r_row;
    assign o_fill_valid  = r_fv;
    assign o_fill_first  = r_ff;
    assign o_fill_last   = r_fl;
    assign o_left_valid  = r_lv;
    assign o_left_first  = r_lf;
    assign o_left_last   = r_ll;
    assign o_right_valid = r_rv;
    assign o_right_first = r_rf;
    assign o_right_last  = r_rl;

endmodule

`default_nettype wire

// ----- tb/crsg_span_checker.sv -----
`timescale 1ns / 1ps

module crsg_span_checker #(
    parameter int COORD_INT_BITS  = 12,
    parameter int COORD_FRAC_BITS = 4
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    crsg_row_if   row_mon,
    crsg_span_if  span_mon,
    crsg_cfg_if   cfg_mon,
    output int    o_fail_count,
    output int    o_pending
);

    localparam int CI = COORD_INT_BITS;
    localparam int CO = COORD_INT_BITS + 2;
    localparam int DW = COORD_INT_BITS + COORD_FRAC_BITS;
    localparam int LW = DW - 1;
    localparam longint HALF_PIX = longint'(1) << (COORD_FRAC_BITS - 1);

    typedef struct packed {
        logic                 valid;
        logic signed [CO-1:0] first_col;
        logic signed [CO-1:0] last_col;
    } t_span;

    typedef struct packed {
        logic [CI-1:0] row;
        t_span         fill;
        t_span         left;
        t_span         right;
    } t_ring_spans;

    // register copy, follows every accepted write
    logic [DW-1:0] ctr_x;
    logic [DW-1:0] ctr_y;
    logic [LW-1:0] rad_out;
    logic [LW-1:0] bord_w;
    logic          fill_on;
    logic          bord_on;

    t_ring_spans pending_spans[$];
    t_ring_spans want_spans;
    t_ring_spans got_spans;

    function automatic longint isqrt(longint v);
        longint unsigned x;
        longint unsigned res;
        longint unsigned b;
        if (v <= 0) return 0;
        x   = v;
        res = 0;
        b   = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= res + b) begin
                x   = x - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return longint'(res);
    endfunction

    function automatic longint fx_floor(longint v);
        return v >>> COORD_FRAC_BITS;
    endfunction

    function automatic longint fx_ceil(longint v);
        return -((-v) >>> COORD_FRAC_BITS);
    endfunction

    // a span whose last column lies left of its first is no span
    function automatic t_span make_span(bit ok, longint first_col, longint last_col);
        t_span s;
        s.valid     = ok && (last_col >= first_col);
        s.first_col = s.valid ? first_col[CO-1:0] : '0;
        s.last_col  = s.valid ? last_col[CO-1:0] : '0;
        return s;
    endfunction

    function automatic t_ring_spans predict_spans(logic [CI-1:0] row_in);
        t_ring_spans res;
        longint cx;
        longint cy;
        longint r;
        longint w;
        longint fr;
        longint dy;
        longint dy2;
        longint in_sq;
        longint out_sq;
        longint d_in;
        longint d_out;
        cx = longint'(ctr_x);
        cy = longint'(ctr_y);
        r  = longint'(rad_out);
        w  = longint'(bord_w);
        fr = r - w;
        if (fr < 0) fr = 0;
        dy     = (longint'(row_in) <<< COORD_FRAC_BITS) + HALF_PIX - cy;
        dy2    = dy * dy;
        in_sq  = fr * fr - dy2;
        out_sq = r * r - dy2;
        res.row   = row_in;
        res.fill  = make_span(1'b0, 0, 0);
        res.left  = make_span(1'b0, 0, 0);
        res.right = make_span(1'b0, 0, 0);
        if (fill_on && fr > 0 && in_sq >= 0) begin
            d_in     = isqrt(in_sq);
            res.fill = make_span(1'b1, fx_floor(cx - d_in), fx_ceil(cx + d_in));
        end
        if (bord_on && w > 0 && out_sq >= 0) begin
            d_out = isqrt(out_sq);
            if (in_sq < 0) begin
                // row passes outside the inner circle: one whole span
                res.left = make_span(1'b1, fx_floor(cx - d_out), fx_ceil(cx + d_out));
            end else begin
                d_in      = isqrt(in_sq);
                res.left  = make_span(1'b1, fx_floor(cx - d_out), fx_ceil(cx - d_in) - 1);
                res.right = make_span(1'b1, fx_ceil(cx + d_in), fx_floor(cx + d_out));
            end
        end
        return res;
    endfunction

    task automatic check_field(string name, int row_no, int want, int got);
        if (want != got) begin
            $display("%0t: row %0d %s expected %0d actual %0d", $time, row_no, name, want, got);
            o_fail_count = o_fail_count + 1;
        end
    endtask

    task automatic check_span(string tag, int row_no, t_span want, t_span got);
        check_field({tag, " valid"}, row_no, want.valid, got.valid);
        check_field({tag, " first"}, row_no, want.first_col, got.first_col);
        check_field({tag, " last"}, row_no, want.last_col, got.last_col);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            ctr_x        = '0;
            ctr_y        = '0;
            rad_out      = '0;
            bord_w       = '0;
            fill_on      = 1'b0;
            bord_on      = 1'b0;
            o_fail_count = 0;
            pending_spans.delete();
            o_pending    = 0;
        end else begin
            if (row_mon.valid && row_mon.ready)
                pending_spans.push_back(predict_spans(row_mon.row));
            if (span_mon.valid && span_mon.ready) begin
                got_spans.row               = span_mon.row_out;
                got_spans.fill.valid        = span_mon.fill_valid;
                got_spans.fill.first_col    = span_mon.fill_first;
                got_spans.fill.last_col     = span_mon.fill_last;
                got_spans.left.valid        = span_mon.left_valid;
                got_spans.left.first_col    = span_mon.left_first;
                got_spans.left.last_col     = span_mon.left_last;
                got_spans.right.valid       = span_mon.right_valid;
                got_spans.right.first_col   = span_mon.right_first;
                got_spans.right.last_col    = span_mon.right_last;
                if (pending_spans.size() == 0) begin
                    $display("%0t: unexpected item for row %0d, expected none actual %h",
                             $time, got_spans.row, got_spans);
                    o_fail_count = o_fail_count + 1;
                end else begin
                    want_spans = pending_spans.pop_front();
                    check_field("row_out", want_spans.row, want_spans.row, got_spans.row);
                    check_span("fill", want_spans.row, want_spans.fill, got_spans.fill);
                    check_span("left", want_spans.row, want_spans.left, got_spans.left);
                    check_span("right", want_spans.row, want_spans.right, got_spans.right);
                end
            end
            o_pending = pending_spans.size();
            if (cfg_mon.valid && cfg_mon.ready) begin
                case (cfg_mon.index)
                    crsg_pkg::CFG_CENTER_X:      ctr_x   = cfg_mon.data;
                    crsg_pkg::CFG_CENTER_Y:      ctr_y   = cfg_mon.data;
                    crsg_pkg::CFG_OUTER_RADIUS:  rad_out = cfg_mon.data[LW-1:0];
                    crsg_pkg::CFG_BORDER_WIDTH:  bord_w  = cfg_mon.data[LW-1:0];
                    crsg_pkg::CFG_FILL_ENABLE:   fill_on = cfg_mon.data[0];
                    crsg_pkg::CFG_BORDER_ENABLE: bord_on = cfg_mon.data[0];
                    default: ;
                endcase
            end
        end
    end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

module tb;

    localparam int CI          = 12;
    localparam int CF          = 4;
    localparam int STALL_LIMIT = 3000;
    localparam int RANDOM_ROWS = 1700;
    localparam int CALM_FROM   = 1450;
    localparam int HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES = 40;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   idle_cycles = 0;
    logic hold_go;
    logic calm;
    bit   hold_done;

    crsg_row_if  #(.P_CI(CI))             row_ch ();
    crsg_span_if #(.P_CI(CI))             span_ch ();
    crsg_cfg_if  #(.P_CI(CI), .P_CF(CF))  cfg_ch ();

    circle_ring_span_generator_unit #(
        .COORD_INT_BITS (CI),
        .COORD_FRAC_BITS(CF)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_row  (row_ch),
        .o_span (span_ch),
        .i_cfg  (cfg_ch)
    );

    crsg_span_checker #(
        .COORD_INT_BITS (CI),
        .COORD_FRAC_BITS(CF)
    ) span_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .row_mon     (row_ch),
        .span_mon    (span_ch),
        .cfg_mon     (cfg_ch),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (!i_rst_n || (row_ch.valid && row_ch.ready) || (span_ch.valid && span_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    task automatic send_row(input logic [CI-1:0] row_val);
        row_ch.valid <= 1'b1;
        row_ch.row   <= row_val;
        do @(posedge i_clk); while (!row_ch.ready);
        if (!calm && $urandom_range(0, 7) == 0) begin
            row_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
    endtask

    task automatic write_reg(input crsg_pkg::t_cfg_idx idx, input logic [CI+CF-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
    endtask

    // the first edge makes sure the last accepted row is already counted
    task automatic wait_drained();
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic apply_setting(input logic [15:0] cx, input logic [15:0] cy,
                                 input logic [14:0] rad, input logic [14:0] bw,
                                 input logic fe, input logic be);
        row_ch.valid <= 1'b0;
        wait_drained();
        write_reg(crsg_pkg::CFG_CENTER_X, cx);
        write_reg(crsg_pkg::CFG_CENTER_Y, cy);
        write_reg(crsg_pkg::CFG_OUTER_RADIUS, {1'b0, rad});
        write_reg(crsg_pkg::CFG_BORDER_WIDTH, {1'b0, bw});
        write_reg(crsg_pkg::CFG_FILL_ENABLE, {15'd0, fe});
        write_reg(crsg_pkg::CFG_BORDER_ENABLE, {15'd0, be});
        cfg_ch.valid <= 1'b0;
    endtask

    // output side: random stalls and one long hold-off
    initial begin
        span_ch.ready <= 1'b0;
        hold_done = 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (hold_go && !hold_done) begin
                hold_done = 1'b1;
                span_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                span_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge i_clk);
            end
            span_ch.ready <= 1'b1;
            @(posedge i_clk);
        end
    end

    initial begin
        logic [15:0] sx;
        logic [15:0] sy;
        logic [14:0] sr;
        logic [14:0] sw;
        logic        sf;
        logic        sb;
        int          sent;
        int          phase;
        int          n_rows;
        int          c_row;
        int          reach;
        int          row_i;

        row_ch.valid <= 1'b0;
        row_ch.row   <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= crsg_pkg::CFG_CENTER_X;
        cfg_ch.data  <= '0;
        hold_go      <= 1'b0;
        calm         <= 1'b0;
        i_rst_n      <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // centre 1000.5, radius 100, border 16: centre row, whole span, miss, row extremes
        apply_setting(16'h3E88, 16'h3E88, 15'h0640, 15'h0100, 1'b1, 1'b1);
        send_row(12'd1000);
        send_row(12'd915);
        send_row(12'd899);
        send_row(12'd1080);
        send_row(12'd0);
        send_row(12'd4095);
        // border wider than radius, inner radius clamped to zero, row through centre
        apply_setting(16'h0808, 16'h0808, 15'd40, 15'd41, 1'b1, 1'b1);
        send_row(12'd128);
        send_row(12'd127);
        send_row(12'd129);
        send_row(12'd130);
        // largest centre, radius and width
        apply_setting(16'hFFFF, 16'hFFFF, 15'h7FFF, 15'h7FFF, 1'b1, 1'b1);
        send_row(12'd4095);
        send_row(12'd4000);
        send_row(12'd2048);
        send_row(12'd0);
        // zero centre, thinnest border, spans can come out empty
        apply_setting(16'h0000, 16'h0000, 15'h7FFF, 15'd1, 1'b1, 1'b1);
        send_row(12'd0);
        send_row(12'd1);
        send_row(12'd1024);
        send_row(12'd2047);
        // enables off, fill only, border only with zero width
        apply_setting(16'h7D00, 16'h7D00, 15'h1F40, 15'h07D0, 1'b0, 1'b0);
        send_row(12'd1990);
        send_row(12'd2300);
        apply_setting(16'h7D00, 16'h7D00, 15'h1F40, 15'h07D0, 1'b1, 1'b0);
        send_row(12'd1995);
        apply_setting(16'h7D00, 16'h7D00, 15'h1F40, 15'h0000, 1'b0, 1'b1);
        send_row(12'd1995);

        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ROWS) begin
            case ($urandom_range(0, 4))
                0:       sx = 16'h0000;
                1:       sx = 16'hFFFF;
                default: sx = 16'($urandom_range(0, 65535));
            endcase
            case ($urandom_range(0, 4))
                0:       sy = 16'h0000;
                1:       sy = 16'hFFFF;
                default: sy = 16'($urandom_range(0, 65535));
            endcase
            case ($urandom_range(0, 5))
                0:       sr = 15'd0;
                1:       sr = 15'h7FFF;
                2, 3:    sr = 15'($urandom_range(16, 1600));
                default: sr = 15'($urandom_range(0, 32767));
            endcase
            case ($urandom_range(0, 6))
                0:       sw = 15'd0;
                1:       sw = 15'h7FFF;
                2:       sw = sr;
                3:       sw = 15'($urandom_range(0, 32767));
                default: sw = 15'($urandom_range(0, sr));
            endcase
            sf = ($urandom_range(0, 3) != 0);
            sb = ($urandom_range(0, 3) != 0);
            apply_setting(sx, sy, sr, sw, sf, sb);
            if (phase == 2)
                hold_go <= 1'b1;
            n_rows = int'($urandom_range(40, 160));
            repeat (n_rows) begin
                // mostly rows that cross the ring, some anywhere
                if ($urandom_range(0, 6) == 0) begin
                    row_i = int'($urandom_range(0, 4095));
                end else begin
                    c_row = int'(sy >> CF);
                    reach = int'(sr >> CF) + 3;
                    row_i = c_row + int'($urandom_range(0, 2 * reach)) - reach;
                    if (row_i < 0) row_i = 0;
                    if (row_i > 4095) row_i = 4095;
                end
                send_row(row_i[CI-1:0]);
                sent = sent + 1;
                if (sent == CALM_FROM)
                    calm <= 1'b1;
            end
            phase = phase + 1;
        end

        row_ch.valid <= 1'b0;
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
